### src/ordered_array_list_engine_macros.svh
// Assertion macros for the ordered array list engine.
// Used by oal_ctrl, which checks its own control logic; expects clk and rst_n in scope.
`ifndef ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH

// Clocked check, switched off while reset is held.
`define OAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define OAL_ASSERT_NEXT(lbl, pre, post, msg) \
  `OAL_ASSERT(lbl, (pre) |=> (post), msg)

`endif

### src/oal_pkg.sv
// Shared types, constants and helper functions for the ordered array list engine.
// No dependencies; the RTL modules refer to it by scoped names and the testbench imports it.
package oal_pkg;

  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;

  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int FOUND_W  = 5;
  localparam int LEN_W    = 5;
  localparam int STATUS_W = 2;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_SEARCH = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_REWIND = 3'd4,
    ACT_READ   = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_PAST_END  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_SHIFT = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_ROTATE = 2'd2,
    OP_SHIFT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [FOUND_W-1:0] found_index;
    logic signed [VALUE_W-1:0] read_value;
    logic [LEN_W-1:0]          list_length;
    logic                      list_full;
    logic [STATUS_W-1:0]       status;
  } out_t;

  // Broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] sel;
    word_t            word;
  } cell_cmd_t;

  // Request value to stored word: truncate, or sign-extend for wide words.
  function automatic word_t to_word(input logic [VALUE_W-1:0] v);
    word_t w;
    for (int i = 0; i < WORD_BITS; i++) begin
      w[i] = v[(i < VALUE_W) ? i : VALUE_W - 1];
    end
    return w;
  endfunction

  // Stored word back to the 32-bit result field, sign-extended.
  function automatic logic [VALUE_W-1:0] from_word(input word_t w);
    logic [VALUE_W-1:0] r;
    for (int i = 0; i < VALUE_W; i++) begin
      r[i] = w[(i < WORD_BITS) ? i : WORD_BITS - 1];
    end
    return r;
  endfunction

endpackage

### src/oal_cell.sv
// One cell of the entry chain: holds a single word, loads the command word on a write to its index,
// and takes its neighbour's on rotate/shift. Depends on oal_pkg.
module oal_cell (
  input  logic              clk,
  input  oal_pkg::cell_cmd_t cmd,
  input  logic [oal_pkg::IDX_W-1:0] idx,
  input  oal_pkg::word_t    nbr_word,
  output oal_pkg::word_t    word
);

  oal_pkg::word_t word_r;
  oal_pkg::word_t word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (cmd.op)
      oal_pkg::OP_WRITE: begin
        if (idx == cmd.sel) word_nxt = cmd.word;
      end
      oal_pkg::OP_ROTATE: begin
        word_nxt = nbr_word;
      end
      // close the gap left by a deleted entry
      oal_pkg::OP_SHIFT: begin
        if (idx >= cmd.sel) word_nxt = nbr_word;
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

### src/oal_ctrl.sv
// Sequencer for the ordered array list engine: request handshake, count, cursor,
// scan of the cell chain and the result register. Depends on oal_pkg and the macro header.
`include "ordered_array_list_engine_macros.svh"

module oal_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  oal_pkg::in_t       in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output oal_pkg::out_t      out_rsp,
  input  oal_pkg::word_t     head_word,
  output oal_pkg::cell_cmd_t cmd
);

  oal_pkg::state_t  state_r,  state_nxt;
  oal_pkg::action_t action_r, action_nxt;
  oal_pkg::status_t status_r, status_nxt;
  oal_pkg::word_t   word_r,   word_nxt;
  logic [oal_pkg::CNT_W-1:0]   count_r,  count_nxt;
  logic [oal_pkg::CNT_W-1:0]   cursor_r, cursor_nxt;
  logic [oal_pkg::IDX_W-1:0]   step_r,   step_nxt;
  logic [oal_pkg::IDX_W-1:0]   loc_r,    loc_nxt;
  logic                        hit_r,    hit_nxt;
  logic [oal_pkg::FOUND_W-1:0] found_r,  found_nxt;
  logic [oal_pkg::VALUE_W-1:0] rd_r,     rd_nxt;
  oal_pkg::out_t               out_r,    out_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic step_last;
  logic match;
  logic out_free;
  oal_pkg::action_t in_act;

  assign in_act    = oal_pkg::action_t'(in_req.action);
  assign step_last = (step_r == oal_pkg::IDX_W'(oal_pkg::CAPACITY - 1));
  // head of the chain holds original entry step_r during the scan
  assign match     = (head_word == word_r) &&
                     (oal_pkg::CNT_W'(step_r) < count_r);
  assign out_free  = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      oal_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_act)
            oal_pkg::ACT_SEARCH, oal_pkg::ACT_DELETE: state_nxt = oal_pkg::ST_SCAN;
            oal_pkg::ACT_READ: begin
              state_nxt = (cursor_r < count_r) ? oal_pkg::ST_SCAN : oal_pkg::ST_DONE;
            end
            default: state_nxt = oal_pkg::ST_DONE;
          endcase
        end
      end
      oal_pkg::ST_SCAN: begin
        if (step_last) begin
          state_nxt = (action_r == oal_pkg::ACT_DELETE && hit_nxt) ?
                      oal_pkg::ST_SHIFT : oal_pkg::ST_DONE;
        end
      end
      oal_pkg::ST_SHIFT: state_nxt = oal_pkg::ST_DONE;
      oal_pkg::ST_DONE: begin
        if (out_free) state_nxt = oal_pkg::ST_IDLE;
      end
      default: state_nxt = oal_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    action_nxt    = action_r;
    status_nxt    = status_r;
    word_nxt      = word_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    step_nxt      = step_r;
    loc_nxt       = loc_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    rd_nxt        = rd_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = oal_pkg::OP_HOLD;
    cmd.sel       = loc_r;
    cmd.word      = word_r;

    case (state_r)
      oal_pkg::ST_IDLE: begin
        if (in_valid) begin
          action_nxt = in_act;
          word_nxt   = oal_pkg::to_word(in_req.value);
          status_nxt = oal_pkg::STS_OK;
          found_nxt  = '1;
          rd_nxt     = '0;
          hit_nxt    = 1'b0;
          step_nxt   = '0;
          case (in_act)
            oal_pkg::ACT_APPEND: begin
              if (count_r == oal_pkg::CNT_W'(oal_pkg::CAPACITY)) begin
                status_nxt = oal_pkg::STS_FULL;
              end else begin
                cmd.op    = oal_pkg::OP_WRITE;
                cmd.sel   = count_r[oal_pkg::IDX_W-1:0];
                cmd.word  = oal_pkg::to_word(in_req.value);
                count_nxt = oal_pkg::CNT_W'(count_r + 1'b1);
              end
            end
            oal_pkg::ACT_SEARCH, oal_pkg::ACT_DELETE: status_nxt = oal_pkg::STS_NOT_FOUND;
            oal_pkg::ACT_CLEAR:  count_nxt  = '0;
            oal_pkg::ACT_REWIND: cursor_nxt = '0;
            oal_pkg::ACT_READ: begin
              if (!(cursor_r < count_r)) status_nxt = oal_pkg::STS_PAST_END;
            end
            default: status_nxt = oal_pkg::STS_OK;
          endcase
        end
      end
      oal_pkg::ST_SCAN: begin
        cmd.op   = oal_pkg::OP_ROTATE;
        step_nxt = step_last ? '0 : oal_pkg::IDX_W'(step_r + 1'b1);
        case (action_r)
          // later hits overwrite: the highest index wins
          oal_pkg::ACT_SEARCH: begin
            if (match) begin
              found_nxt  = oal_pkg::FOUND_W'(step_r);
              status_nxt = oal_pkg::STS_OK;
            end
          end
          oal_pkg::ACT_DELETE: begin
            if (match && !hit_r) begin
              loc_nxt = step_r;
              hit_nxt = 1'b1;
            end
          end
          oal_pkg::ACT_READ: begin
            if (oal_pkg::CNT_W'(step_r) == cursor_r) rd_nxt = oal_pkg::from_word(head_word);
            if (step_last) cursor_nxt = oal_pkg::CNT_W'(cursor_r + 1'b1);
          end
          default: begin
            hit_nxt = hit_r;
          end
        endcase
      end
      oal_pkg::ST_SHIFT: begin
        cmd.op     = oal_pkg::OP_SHIFT;
        cmd.sel    = loc_r;
        count_nxt  = oal_pkg::CNT_W'(count_r - 1'b1);
        status_nxt = oal_pkg::STS_OK;
      end
      oal_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.found_index = found_r;
          out_nxt.read_value  = rd_r;
          out_nxt.list_length = oal_pkg::LEN_W'(count_r);
          out_nxt.list_full   = (count_r == oal_pkg::CNT_W'(oal_pkg::CAPACITY));
          out_nxt.status      = status_r;
        end
      end
      default: begin
        out_nxt = out_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oal_pkg::ST_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      step_r      <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      step_r      <= step_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= action_nxt;
    status_r <= status_nxt;
    word_r   <= word_nxt;
    loc_r    <= loc_nxt;
    found_r  <= found_nxt;
    rd_r     <= rd_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall  = (state_r != oal_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  `OAL_ASSERT_NEXT(a_scan_runs_full_lap, state_r == oal_pkg::ST_SCAN && !step_last, state_r == oal_pkg::ST_SCAN, "scan left before a full lap of the chain")
  `OAL_ASSERT(a_shift_after_hit, state_r == oal_pkg::ST_SHIFT |-> action_r == oal_pkg::ACT_DELETE && hit_r, "entries moved up without a delete hit")
  `OAL_ASSERT_NEXT(a_append_grows, state_r == oal_pkg::ST_IDLE && in_valid && in_act == oal_pkg::ACT_APPEND && count_r != oal_pkg::CNT_W'(oal_pkg::CAPACITY), count_r == $past(count_r) + 1'b1, "append did not grow the list")
  `OAL_ASSERT_NEXT(a_read_advances, state_r == oal_pkg::ST_SCAN && action_r == oal_pkg::ACT_READ && step_last, cursor_r == $past(cursor_r) + 1'b1, "read did not advance the cursor")

endmodule

### src/ordered_array_list_engine.sv
// Top level of the ordered array list engine: a ring of entry cells and its sequencer.
// Depends on oal_pkg, oal_cell and oal_ctrl.

// One request at a time. Append, clear, rewind and unknown actions go from
// IDLE straight to DONE. Search, delete and read next rotate the whole ring
// of CAPACITY cells once past the head comparator in SCAN; a delete that finds
// its value then moves the later entries up in SHIFT. Read past end goes
// straight to DONE. A new request is taken in the cycle after the previous
// result enters the output register, even if that result is still held by
// out_stall.
module ordered_array_list_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  oal_pkg::in_t  in_req,
  output logic          out_valid,
  input  logic          out_stall,
  output oal_pkg::out_t out_rsp
);

  oal_pkg::cell_cmd_t cmd;
  oal_pkg::word_t     cell_word [oal_pkg::CAPACITY];

  oal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .head_word (cell_word[0]),
    .cmd       (cmd)
  );

  // data moves toward cell 0; cell 0 wraps round to the tail
  for (genvar g = 0; g < oal_pkg::CAPACITY; g++) begin : g_cell
    oal_pkg::word_t nbr;
    if (g == oal_pkg::CAPACITY - 1) begin : g_tail
      assign nbr = cell_word[0];
    end else begin : g_body
      assign nbr = cell_word[g+1];
    end

    oal_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .idx      (oal_pkg::IDX_W'(g)),
      .nbr_word (nbr),
      .word     (cell_word[g])
    );
  end

endmodule

### tb/tb_ordered_array_list_engine.sv
// Self-checking testbench for ordered_array_list_engine: mirrors the list, count and read cursor,
// drives requests with random gaps and output stalls, and compares every response field.
// Depends on oal_pkg and the RTL of ordered_array_list_engine.
module tb_ordered_array_list_engine;
  import oal_pkg::*;

  localparam int ITEMS       = 1350;
  localparam int CALM_TAIL   = 120;
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = CAPACITY + 6;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;

  class list_scoreboard;
    word_t       mirror [CAPACITY];
    int unsigned fill_cnt;
    int unsigned rd_ptr;
    out_t        expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned act_seen [8];
    int unsigned sts_seen [4];

    function new();
      fill_cnt = 0;
      rd_ptr   = 0;
      errors   = 0;
      checked  = 0;
      foreach (act_seen[i]) act_seen[i] = 0;
      foreach (sts_seen[i]) sts_seen[i] = 0;
    endfunction

    // Work out the response to an accepted request and update the mirror.
    function void note(in_t r);
      out_t  e;
      word_t w;
      int    hit;
      w = r.value;
      hit = -1;
      e.found_index = '1;
      e.read_value  = '0;
      e.status      = STS_OK;
      case (r.action)
        ACT_APPEND: begin
          if (fill_cnt >= CAPACITY) begin
            e.status = STS_FULL;
          end else begin
            mirror[fill_cnt] = w;
            fill_cnt++;
          end
        end
        ACT_SEARCH: begin
          for (int i = 0; i < fill_cnt; i++) if (mirror[i] == w) hit = i;
          if (hit < 0) e.status = STS_NOT_FOUND;
          else e.found_index = FOUND_W'(hit);
        end
        ACT_DELETE: begin
          // first match wins, so scan downwards
          for (int i = fill_cnt - 1; i >= 0; i--) if (mirror[i] == w) hit = i;
          if (hit < 0) begin
            e.status = STS_NOT_FOUND;
          end else begin
            for (int i = hit; i + 1 < fill_cnt; i++) mirror[i] = mirror[i + 1];
            fill_cnt--;
          end
        end
        ACT_CLEAR: fill_cnt = 0;
        ACT_REWIND: rd_ptr = 0;
        ACT_READ: begin
          if (rd_ptr < fill_cnt) begin
            e.read_value = mirror[rd_ptr];
            rd_ptr++;
          end else begin
            e.status = STS_PAST_END;
          end
        end
        default: ;
      endcase
      e.list_length = LEN_W'(fill_cnt);
      e.list_full   = (fill_cnt == CAPACITY);
      act_seen[r.action]++;
      sts_seen[e.status]++;
      expected_q.push_back(e);
    endfunction

    function void field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check(out_t got);
      out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: response with no request outstanding: expected none, got %h",
                 $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      field("found_index", 32'(e.found_index), 32'(got.found_index));
      field("read_value",  e.read_value,       got.read_value);
      field("list_length", 32'(e.list_length), 32'(got.list_length));
      field("list_full",   32'(e.list_full),   32'(got.list_full));
      field("status",      32'(e.status),      32'(got.status));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_stall = 1'b0;
  in_t  in_req    = '0;
  logic in_stall;
  logic out_valid;
  out_t out_rsp;

  list_scoreboard sb = new();
  int unsigned sent_cnt  = 0;
  int unsigned cycle_cnt = 0;
  bit          calm      = 1'b0;
  bit          hold_req  = 1'b0;

  ordered_array_list_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(out_rsp);
  end

  // Receiver: short random stall bursts, and a long hold-off to back the block up.
  initial begin : rx_stall
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4, 5, 6: return $urandom_range(1, 6);
      default: return $urandom();
    endcase
  endfunction

  // Drive one request, hold it until taken, then maybe leave a gap.
  task automatic issue(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val);
    in_t r;
    int  gap;
    r.action = act;
    r.value  = val;
    in_req   <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(r);
    if (act <= ACT_READ) sent_cnt++;
    if (sent_cnt == HOLD_AT) hold_req = 1'b1;
    calm = (sent_cnt >= ITEMS - CALM_TAIL);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic mixed_burst(input int n);
    int p;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      if (p < 30)      issue(ACT_APPEND, pick_value());
      else if (p < 50) issue(ACT_SEARCH, pick_value());
      else if (p < 68) issue(ACT_DELETE, pick_value());
      else if (p < 85) issue(ACT_READ, $urandom());
      else if (p < 91) issue(ACT_REWIND, $urandom());
      else if (p < 94) issue(ACT_CLEAR, $urandom());
      else             issue($urandom_range(0, 1) ? ACT_UNDEF_HI : ACT_UNDEF_LO, $urandom());
    end
  endtask

  initial begin : stimulus
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corners
    issue(ACT_READ,   32'h0);
    issue(ACT_SEARCH, 32'h0);
    issue(ACT_DELETE, 32'h0);
    // extremes, with a duplicate of the most negative word
    issue(ACT_APPEND, 32'h8000_0000);
    issue(ACT_APPEND, 32'h7fff_ffff);
    issue(ACT_APPEND, 32'h0000_0000);
    issue(ACT_APPEND, 32'hffff_ffff);
    issue(ACT_APPEND, 32'h8000_0000);
    issue(ACT_SEARCH, 32'h8000_0000);
    issue(ACT_SEARCH, 32'h0000_3039);
    issue(ACT_READ,   32'h0);
    issue(ACT_READ,   32'h0);
    issue(ACT_DELETE, 32'h8000_0000);
    issue(ACT_DELETE, 32'h0000_0007);
    issue(ACT_REWIND, 32'h0);
    issue(ACT_READ,   32'h0);
    issue(ACT_UNDEF_LO, 32'hffff_ffff);
    issue(ACT_UNDEF_HI, 32'h5555_aaaa);
    issue(ACT_CLEAR,  32'h0);
    issue(ACT_READ,   32'h0);

    while (sent_cnt < ITEMS) begin
      case ($urandom_range(0, 3))
        0: begin
          // fill, often past capacity
          n = $urandom_range(4, 19);
          for (int k = 0; k < n; k++) issue(ACT_APPEND, pick_value());
        end
        1: begin
          n = $urandom_range(3, 18);
          issue(ACT_REWIND, $urandom());
          for (int k = 0; k < n; k++) issue(ACT_READ, $urandom());
        end
        2: mixed_burst(12);
        default: begin
          n = $urandom_range(4, 10);
          for (int k = 0; k < n; k++) begin
            issue($urandom_range(0, 1) ? ACT_DELETE : ACT_SEARCH, pick_value());
          end
        end
      endcase
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.pending() != 0) begin
      $display("%0t: %0d responses never arrived: expected 0 left, got %0d",
               $time, sb.pending(), sb.pending());
      sb.errors++;
    end
    $display("Ran %0d requests: %0d appends, %0d searches, %0d deletes, %0d reads, %0d clears",
             sent_cnt, sb.act_seen[ACT_APPEND], sb.act_seen[ACT_SEARCH],
             sb.act_seen[ACT_DELETE], sb.act_seen[ACT_READ], sb.act_seen[ACT_CLEAR]);
    $display("%0d responses checked; %0d full rejects, %0d not found, %0d reads past end",
             sb.checked, sb.sts_seen[STS_FULL], sb.sts_seen[STS_NOT_FOUND],
             sb.sts_seen[STS_PAST_END]);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
